// ===== hw/rtl/vgim_pkg.sv =====
// Shared constants, types and codes of the voxel grid index mapper.
package vgim_pkg;

   localparam int GRID_X = 512;
   localparam int GRID_Y = 512;
   localparam int GRID_Z = 16;
   localparam int VOL    = GRID_X * GRID_Y * GRID_Z;

   localparam int GRID_MAX = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
                                               : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
   localparam int IDX_W  = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
   localparam int COORD_W = 24;
   localparam int CELL_W  = 16;
   localparam int REM_W   = CELL_W + IDX_W;
   localparam int NUM_AXES = 3;

   localparam logic [1:0] OP_POINT   = 2'd0;
   localparam logic [1:0] OP_OFFSET  = 2'd1;
   localparam logic [1:0] OP_INDICES = 2'd2;

   localparam int ADDR_W = 5;
   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [2:0] REG_CELL_X   = 3'd3;
   localparam logic [2:0] REG_CELL_Y   = 3'd4;
   localparam logic [2:0] REG_CELL_Z   = 3'd5;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] dv;
      logic [IDX_W-1:0] q;
   } axis_type;

   typedef struct packed {
      logic                      ok;
      logic                      div;
      axis_type [NUM_AXES-1:0]   ax;
   } work_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic [CELL_W-1:0]         cell_x;
      logic [CELL_W-1:0]         cell_y;
      logic [CELL_W-1:0]         cell_z;
   } cfg_type;

endpackage

// ===== hw/rtl/vgim_req_if.sv =====
// Request channel interface of the voxel grid index mapper.
interface vgim_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [23:0] point_x;
   logic [23:0] point_y;
   logic [23:0] point_z;
   logic [22:0] offset_in;
   logic [9:0]  index_x_in;
   logic [9:0]  index_y_in;
   logic [4:0]  index_z_in;

   modport source (output valid, operation, point_x, point_y, point_z, offset_in,
                   index_x_in, index_y_in, index_z_in, input ready);
   modport sink (input valid, operation, point_x, point_y, point_z, offset_in,
                 index_x_in, index_y_in, index_z_in, output ready);
endinterface

// ===== hw/rtl/vgim_rsp_if.sv =====
// Result channel interface of the voxel grid index mapper.
interface vgim_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [8:0]  voxel_x;
   logic [8:0]  voxel_y;
   logic [3:0]  voxel_z;
   logic [21:0] linear_offset;
   logic [31:0] centre_x;
   logic [31:0] centre_y;
   logic [31:0] centre_z;

   modport source (output valid, valid_res, voxel_x, voxel_y, voxel_z, linear_offset,
                   centre_x, centre_y, centre_z, input ready);
   modport sink (input valid, valid_res, voxel_x, voxel_y, voxel_z, linear_offset,
                 centre_x, centre_y, centre_z, output ready);
endinterface

// ===== hw/rtl/voxel_grid_index_mapper_top.sv =====
// Top level of the voxel grid index mapper: register file, input stage, divider chain, output.
//
//   channel   direction  handshake             content
//   req_ch    in         valid/ready           operation, point, offset, indices
//   rsp_ch    out        valid/ready           valid_res, voxel indices, offset, centre
//   csr_*     in         APB write, pready=1   origin and cell size registers
//
// One item per cycle while rsp_ch.ready holds; an item passes the input stage, one divider
// cell per quotient bit and the output register. Each cell holds only when its successor is
// full and stalled, so bubbles are absorbed. Reset is synchronous and clears all
// valid flags; registers reset to origin 0 and cell size 256.
module voxel_grid_index_mapper_top (
   input  logic                          clock,
   input  logic                          reset,
   vgim_req_if.sink                      req_ch,
   vgim_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [vgim_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   vgim_pkg::cfg_type cfg_ff;
   logic [2:0]        reg_idx;

   logic               vld [vgim_pkg::IDX_W+1];
   logic               rdy [vgim_pkg::IDX_W+1];
   vgim_pkg::work_type wrk [vgim_pkg::IDX_W+1];
   logic               back_ready;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
         cfg_ff.cell_x   <= 16'd256;
         cfg_ff.cell_y   <= 16'd256;
         cfg_ff.cell_z   <= 16'd256;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            vgim_pkg::REG_ORIGIN_X: cfg_ff.origin_x <= csr_pwdata[23:0];
            vgim_pkg::REG_ORIGIN_Y: cfg_ff.origin_y <= csr_pwdata[23:0];
            vgim_pkg::REG_ORIGIN_Z: cfg_ff.origin_z <= csr_pwdata[23:0];
            vgim_pkg::REG_CELL_X:   cfg_ff.cell_x   <= csr_pwdata[15:0];
            vgim_pkg::REG_CELL_Y:   cfg_ff.cell_y   <= csr_pwdata[15:0];
            vgim_pkg::REG_CELL_Z:   cfg_ff.cell_z   <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         vgim_pkg::REG_ORIGIN_X: csr_prdata = {8'd0, cfg_ff.origin_x};
         vgim_pkg::REG_ORIGIN_Y: csr_prdata = {8'd0, cfg_ff.origin_y};
         vgim_pkg::REG_ORIGIN_Z: csr_prdata = {8'd0, cfg_ff.origin_z};
         vgim_pkg::REG_CELL_X:   csr_prdata = {16'd0, cfg_ff.cell_x};
         vgim_pkg::REG_CELL_Y:   csr_prdata = {16'd0, cfg_ff.cell_y};
         vgim_pkg::REG_CELL_Z:   csr_prdata = {16'd0, cfg_ff.cell_z};
         default:                csr_prdata = '0;
      endcase
   end

   vgim_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (cfg_ff),
      .out_valid (vld[0]),
      .out_work  (wrk[0]),
      .out_ready (rdy[0])
   );

   for (genvar i = 0; i < vgim_pkg::IDX_W; i++) begin : g_cell
      vgim_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[i]),
         .in_work   (wrk[i]),
         .in_ready  (rdy[i]),
         .out_valid (vld[i+1]),
         .out_work  (wrk[i+1]),
         .out_ready (rdy[i+1])
      );
   end

   assign rdy[vgim_pkg::IDX_W] = back_ready;

   vgim_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (vld[vgim_pkg::IDX_W]),
      .in_work  (wrk[vgim_pkg::IDX_W]),
      .in_ready (back_ready),
      .cfg      (cfg_ff),
      .rsp_ch   (rsp_ch)
   );

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.valid_res |->
         rsp_ch.linear_offset == '0 && rsp_ch.centre_x == '0 && rsp_ch.voxel_x == '0)
      else $error("invalid result carries nonzero fields");

   a_offset_match: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.valid_res |->
         32'(rsp_ch.linear_offset) == (32'(rsp_ch.voxel_x) * vgim_pkg::GRID_Y +
            32'(rsp_ch.voxel_y)) * vgim_pkg::GRID_Z + 32'(rsp_ch.voxel_z))
      else $error("linear offset does not match voxel indices");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.valid_res |->
         32'(rsp_ch.voxel_x) < vgim_pkg::GRID_X && 32'(rsp_ch.voxel_z) < vgim_pkg::GRID_Z)
      else $error("valid result outside grid");

endmodule

// ===== hw/rtl/vgim_front.sv =====
// Input stage: decodes the operation, checks bounds and seeds the divider chain.
module vgim_front (
   input  logic                clock,
   input  logic                reset,
   vgim_req_if.sink            req_ch,
   input  vgim_pkg::cfg_type   cfg,
   output logic                out_valid,
   output vgim_pkg::work_type  out_work,
   input  logic                out_ready
);

   logic               valid_ff, valid_in;
   vgim_pkg::work_type work_ff, work_in;

   logic [vgim_pkg::NUM_AXES-1:0][vgim_pkg::COORD_W-1:0] pt, org;
   logic [vgim_pkg::NUM_AXES-1:0][vgim_pkg::CELL_W-1:0]  cel;
   logic [vgim_pkg::NUM_AXES-1:0]                        ax_ok;
   logic [vgim_pkg::NUM_AXES-1:0][vgim_pkg::COORD_W:0]   dif;
   logic [22:0] off;
   logic [31:0] off_z, off_y;

   assign pt  = {req_ch.point_z, req_ch.point_y, req_ch.point_x};
   assign org = {cfg.origin_z, cfg.origin_y, cfg.origin_x};
   assign cel = {cfg.cell_z, cfg.cell_y, cfg.cell_x};

   assign req_ch.ready = !valid_ff || out_ready;
   assign valid_in = req_ch.valid || (valid_ff && !out_ready);

   always_comb begin
      off   = req_ch.offset_in;
      off_z = 32'(off) / vgim_pkg::GRID_Z;
      off_y = off_z / vgim_pkg::GRID_Y;
      work_in = '0;
      for (int a = 0; a < vgim_pkg::NUM_AXES; a++) begin
         dif[a] = {pt[a][vgim_pkg::COORD_W-1], pt[a]} - {org[a][vgim_pkg::COORD_W-1], org[a]};
         ax_ok[a] = !dif[a][vgim_pkg::COORD_W] && (cel[a] != '0) &&
                    ({1'b0, dif[a][vgim_pkg::COORD_W-1:0]} <
                     {cel[a], {vgim_pkg::IDX_W{1'b0}}});
      end
      unique case (req_ch.operation)
         vgim_pkg::OP_POINT: begin
            work_in.div = 1'b1;
            work_in.ok  = &ax_ok;
            for (int a = 0; a < vgim_pkg::NUM_AXES; a++) begin
               work_in.ax[a].rem = vgim_pkg::REM_W'(dif[a][vgim_pkg::COORD_W-1:0]);
               work_in.ax[a].dv  = vgim_pkg::REM_W'(cel[a]) << (vgim_pkg::IDX_W - 1);
            end
         end
         vgim_pkg::OP_OFFSET: begin
            work_in.ok = 32'(off) < vgim_pkg::VOL;
            work_in.ax[2].q = vgim_pkg::IDX_W'(32'(off) % vgim_pkg::GRID_Z);
            work_in.ax[1].q = vgim_pkg::IDX_W'(off_z % vgim_pkg::GRID_Y);
            work_in.ax[0].q = vgim_pkg::IDX_W'(off_y % vgim_pkg::GRID_X);
         end
         vgim_pkg::OP_INDICES: begin
            work_in.ok = (32'(req_ch.index_x_in) < vgim_pkg::GRID_X) &&
                         (32'(req_ch.index_y_in) < vgim_pkg::GRID_Y) &&
                         (32'(req_ch.index_z_in) < vgim_pkg::GRID_Z);
            work_in.ax[0].q = vgim_pkg::IDX_W'(req_ch.index_x_in);
            work_in.ax[1].q = vgim_pkg::IDX_W'(req_ch.index_y_in);
            work_in.ax[2].q = vgim_pkg::IDX_W'(req_ch.index_z_in);
         end
         default: begin
            work_in.ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// ===== hw/rtl/vgim_div_cell.sv =====
// Divider cell: one quotient bit per axis for point items (others pass unchanged), then hands the item to its neighbor.
module vgim_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  vgim_pkg::work_type  in_work,
   output logic                in_ready,
   output logic                out_valid,
   output vgim_pkg::work_type  out_work,
   input  logic                out_ready
);

   logic               valid_ff;
   vgim_pkg::work_type work_ff, work_in;
   logic               bit_q;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      work_in = in_work;
      bit_q   = 1'b0;
      if (in_work.div) begin
         for (int a = 0; a < vgim_pkg::NUM_AXES; a++) begin
            bit_q = in_work.ax[a].rem >= in_work.ax[a].dv;
            if (bit_q) begin
               work_in.ax[a].rem = in_work.ax[a].rem - in_work.ax[a].dv;
            end
            work_in.ax[a].q  = {in_work.ax[a].q[vgim_pkg::IDX_W-2:0], bit_q};
            work_in.ax[a].dv = in_work.ax[a].dv >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(work_ff))
      else $error("divider cell dropped a stalled item");

endmodule

// ===== hw/rtl/vgim_back.sv =====
// Output stage: final grid check, linear offset and voxel centre.
module vgim_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  vgim_pkg::work_type  in_work,
   output logic                in_ready,
   input  vgim_pkg::cfg_type   cfg,
   vgim_rsp_if.source          rsp_ch
);

   logic        valid_ff;
   logic        ok;
   logic        res_ok_ff;
   logic [8:0]  vx_ff, vy_ff;
   logic [3:0]  vz_ff;
   logic [21:0] lin_ff, lin_in;
   logic [31:0] cx_ff, cy_ff, cz_ff;
   logic [vgim_pkg::NUM_AXES-1:0][31:0] cen;
   logic [vgim_pkg::NUM_AXES-1:0][vgim_pkg::COORD_W-1:0] org;
   logic [vgim_pkg::NUM_AXES-1:0][vgim_pkg::CELL_W-1:0]  cel;
   logic [vgim_pkg::NUM_AXES-1:0][vgim_pkg::REM_W-1:0]   prod;

   assign org = {cfg.origin_z, cfg.origin_y, cfg.origin_x};
   assign cel = {cfg.cell_z, cfg.cell_y, cfg.cell_x};
   assign in_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      ok = in_work.ok;
      if (in_work.div) begin
         ok = ok && (32'(in_work.ax[0].q) < vgim_pkg::GRID_X) &&
                    (32'(in_work.ax[1].q) < vgim_pkg::GRID_Y) &&
                    (32'(in_work.ax[2].q) < vgim_pkg::GRID_Z);
      end
      for (int a = 0; a < vgim_pkg::NUM_AXES; a++) begin
         prod[a] = vgim_pkg::REM_W'(in_work.ax[a].q) * vgim_pkg::REM_W'(cel[a]);
         cen[a]  = {{(32 - vgim_pkg::COORD_W){org[a][vgim_pkg::COORD_W-1]}}, org[a]} +
                   32'(prod[a]) + 32'(cel[a] >> 1);
      end
      lin_in = 22'((32'(in_work.ax[0].q) * vgim_pkg::GRID_Y + 32'(in_work.ax[1].q)) *
                   vgim_pkg::GRID_Z + 32'(in_work.ax[2].q));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         res_ok_ff <= ok;
         vx_ff     <= ok ? 9'(in_work.ax[0].q) : '0;
         vy_ff     <= ok ? 9'(in_work.ax[1].q) : '0;
         vz_ff     <= ok ? 4'(in_work.ax[2].q) : '0;
         lin_ff    <= ok ? lin_in : '0;
         cx_ff     <= ok ? cen[0] : '0;
         cy_ff     <= ok ? cen[1] : '0;
         cz_ff     <= ok ? cen[2] : '0;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.valid_res     = res_ok_ff;
   assign rsp_ch.voxel_x       = vx_ff;
   assign rsp_ch.voxel_y       = vy_ff;
   assign rsp_ch.voxel_z       = vz_ff;
   assign rsp_ch.linear_offset = lin_ff;
   assign rsp_ch.centre_x      = cx_ff;
   assign rsp_ch.centre_y      = cy_ff;
   assign rsp_ch.centre_z      = cz_ff;

endmodule
